// ===== rtl/core/igmp_pkg.sv =====
// Package for the IGMP snooping table: constants, widths and sequencer state type.
// Used by every module in rtl/core; depends on nothing.
package igmp_pkg;
	localparam int NumEntriesDef = 16;
	localparam logic [7:0] TypeQuery = 8'h11;
	localparam logic [7:0] TypeReport = 8'h16;
	localparam logic [7:0] TypeLeave = 8'h17;
	localparam logic [31:0] AllHosts = 32'hE000_0001;
	localparam logic [10:0] MinLen = 11'd30;
	localparam logic [15:0] AgeLimitReset = 16'd260;
	localparam int MaxResults = 16;

	localparam logic [1:0] ActNone = 2'd0;
	localparam logic [1:0] ActAdd = 2'd1;
	localparam logic [1:0] ActDel = 2'd2;
	localparam logic [1:0] ActPort = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_FWD,
		ST_AGE,
		ST_OUT,
		ST_TICK_END
	} state_t;
endpackage

// ===== rtl/core/igmp_ctrl.sv =====
// Sequencer and table storage of the IGMP snooping table.
// One entry is visited per cycle by a shared compare unit; depends on igmp_pkg.
module igmp_ctrl import igmp_pkg::*; #(
	parameter int NUM_ENTRIES = NumEntriesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [166:0] in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [62:0] out_item
);
	localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CW = $clog2(NUM_ENTRIES + 1);

	// Table storage; valid bits reset, payload undefined until written.
	logic [NUM_ENTRIES-1:0] valid_q;
	logic [31:0] grp_q [NUM_ENTRIES];
	logic [31:0] cli_q [NUM_ENTRIES];
	logic [2:0]  port_q [NUM_ENTRIES];
	logic [47:0] mac_q [NUM_ENTRIES];
	logic [15:0] age_q [NUM_ENTRIES];
	logic        qv_q;
	logic [2:0]  qport_q;
	logic [15:0] qage_q;
	logic [15:0] limit_q;

	// Latched request.
	logic        rtype_q;
	logic [10:0] len_q;
	logic [7:0]  ty_q;
	logic [2:0]  rx_q;
	logic [31:0] g_q, s_q, d_q;
	logic [47:0] m_q;

	state_t st_q, st_d;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] ix;
	logic found_q, free_q;
	logic [IW-1:0] hit_q, fr_q;
	logic [4:0] nres_q;
	logic obuf_v_q, pend_last_q;
	logic [62:0] obuf_q;
	logic [62:0] hold_q;

	assign ix = cnt_q[IW-1:0];
	assign in_ready = (st_q == ST_IDLE) && !obuf_v_q;
	assign out_valid = obuf_v_q;
	assign out_item = obuf_q;

	// Shared compare unit: one entry per cycle.
	logic match;
	assign match = valid_q[ix] && grp_q[ix] == g_q && cli_q[ix] == s_q;
	logic scan_done;
	assign scan_done = (cnt_q == CW'(NUM_ENTRIES - 1));

	// The aging scan advances only when the result register can take a new transaction.
	logic age_go, age_emit;
	assign age_go = !obuf_v_q || out_ready;
	assign age_emit = valid_q[ix] && !(age_q[ix] > 16'd1) && (nres_q < 5'(MaxResults));

	// Decision logic for packet after scan.
	logic short_drop, type_bad, drop;
	assign short_drop = len_q < MinLen;
	assign type_bad = !(ty_q == TypeQuery || ty_q == TypeReport || ty_q == TypeLeave);
	assign drop = short_drop || type_bad || (ty_q == TypeLeave && !found_q) ||
		(ty_q == TypeReport && !found_q && !free_q);

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (in_valid && in_ready) st_d = in_item[0] ? ST_AGE : ST_SCAN;
			ST_SCAN: if (scan_done) st_d = ST_UPDATE;
			ST_UPDATE: st_d = drop ? ST_OUT : ST_FWD;
			ST_FWD: st_d = ST_OUT;
			ST_AGE: if (scan_done && age_go) st_d = ST_TICK_END;
			ST_OUT: if (!obuf_v_q) st_d = ST_IDLE;
			ST_TICK_END: if (!obuf_v_q) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	logic [7:0] others, fwd;
	logic [2:0] cmp_port;
	logic s_hit;
	assign others = ~(8'd1 << rx_q);
	assign s_hit = found_q || ty_q == TypeReport;
	always_comb begin
		cmp_port = (ty_q == TypeReport) ? port_q[hit_q] : rx_q;
		if (ty_q == TypeQuery) begin
			if (d_q == AllHosts || !found_q) fwd = others;
			else fwd = 8'd1 << port_q[hit_q];
		end else if (qv_q) begin
			fwd = (cmp_port != qport_q) ? (8'd1 << qport_q) : 8'd0;
		end else begin
			fwd = others;
		end
	end

	// Output item: kind, acc, send, mask, act, idx, mac, last.
	function automatic logic [62:0] pack(logic kind, logic acc, logic [7:0] f,
		logic [1:0] act, logic [IW-1:0] idx, logic [47:0] mac, logic lst);
		logic [3:0] i4;
		i4 = 4'(idx);
		return {lst, mac, i4, act, f[4:0], (f != 8'd0), acc, kind};
	endfunction

	logic [1:0] act_q;
	logic [47:0] emac_q;

	// The result register is loaded in these cycles; otherwise an accepted result empties it.
	logic obuf_set;
	assign obuf_set = (st_q == ST_UPDATE && drop) || (st_q == ST_FWD) ||
		(st_q == ST_AGE && age_go && age_emit && pend_last_q) ||
		(st_q == ST_TICK_END && !obuf_v_q && pend_last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obuf_v_q <= 1'b0;
		end else if (obuf_set) begin
			obuf_v_q <= 1'b1;
		end else if (out_ready) begin
			obuf_v_q <= 1'b0;
		end
	end

	// Sequencer datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			valid_q <= '0;
			qv_q <= 1'b0;
			qport_q <= '0;
			qage_q <= '0;
			limit_q <= AgeLimitReset;
			cnt_q <= '0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			nres_q <= '0;
			pend_last_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) limit_q <= cfg_data;
			case (st_q)
				ST_IDLE: begin
					cnt_q <= '0;
					found_q <= 1'b0;
					free_q <= 1'b0;
					nres_q <= '0;
					pend_last_q <= 1'b0;
					if (in_valid && in_ready) begin
						{m_q, d_q, s_q, g_q, rx_q, ty_q, len_q, rtype_q} <= in_item;
					end
				end
				ST_SCAN: begin
					if (match && !found_q) begin
						found_q <= 1'b1;
						hit_q <= ix;
					end
					if (!valid_q[ix] && !free_q) begin
						free_q <= 1'b1;
						fr_q <= ix;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_UPDATE: begin
					if (drop) begin
						obuf_q <= pack(1'b0, 1'b0, 8'd0, ActNone, '0, 48'd0, 1'b1);
					end else if (ty_q == TypeQuery) begin
						qport_q <= rx_q;
						qage_q <= limit_q;
						qv_q <= 1'b1;
						act_q <= ActNone;
						emac_q <= '0;
						hit_q <= found_q ? hit_q : '0;
					end else if (ty_q == TypeLeave) begin
						valid_q[hit_q] <= 1'b0;
						act_q <= ActDel;
						emac_q <= mac_q[hit_q];
						found_q <= 1'b0;
					end else if (found_q && port_q[hit_q] != rx_q) begin
						age_q[hit_q] <= limit_q;
						port_q[hit_q] <= rx_q;
						act_q <= ActPort;
						emac_q <= mac_q[hit_q];
					end else begin
						if (!found_q) hit_q <= fr_q;
						grp_q[found_q ? hit_q : fr_q] <= g_q;
						cli_q[found_q ? hit_q : fr_q] <= s_q;
						port_q[found_q ? hit_q : fr_q] <= rx_q;
						mac_q[found_q ? hit_q : fr_q] <= m_q;
						age_q[found_q ? hit_q : fr_q] <= limit_q;
						valid_q[found_q ? hit_q : fr_q] <= 1'b1;
						act_q <= ActAdd;
						emac_q <= m_q;
						found_q <= 1'b1;
					end
				end
				ST_FWD: begin
					obuf_q <= pack(1'b0, 1'b1, (s_hit || ty_q != TypeReport) ? fwd : fwd,
						act_q, (ty_q == TypeQuery) ? '0 : hit_q, emac_q, 1'b1);
				end
				ST_AGE: begin
					if (age_go) begin
						// Emit the held result once the next expiry or scan end is known.
						if (valid_q[ix]) begin
							if (age_q[ix] > 16'd1) begin
								age_q[ix] <= age_q[ix] - 16'd1;
							end else begin
								valid_q[ix] <= 1'b0;
								if (age_emit) begin
									if (pend_last_q) begin
										obuf_q <= hold_q;
									end
									hold_q <= pack(1'b1, 1'b1, 8'd0, ActDel, ix, mac_q[ix], 1'b0);
									pend_last_q <= 1'b1;
									nres_q <= nres_q + 1'b1;
								end
							end
						end
						if (!scan_done) cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_TICK_END: begin
					if (!obuf_v_q) begin
						if (pend_last_q) begin
							obuf_q <= {1'b1, hold_q[61:0]};
						end
						if (qv_q && qage_q > 16'd1) qage_q <= qage_q - 16'd1;
						else qv_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	logic unused;
	assign unused = rtype_q;
endmodule

// ===== rtl/core/igmp_snooping_table.sv =====
// Top level of the IGMP snooping table: stream ports and configuration.
// Instantiates igmp_ctrl; depends on igmp_pkg.
//
// Usage: one input transaction on s_axis carries a packet (tuser 0) or an
// aging tick (tuser 1). A packet yields one verdict on m_axis with tlast 1.
// A tick yields one result per expired entry, up to MaxResults, the final one with tlast 1;
// a tick with no expiry yields nothing.
// A packet verdict follows a scan of every table entry, one entry per cycle
// through the shared compare unit, then the update and forward states; a
// dropped packet skips the forward state. A tick scans one entry per cycle while
// the result register can take a new result; its final result follows the scan.
// Only one item is in work at a time; s_axis_tready stays low meanwhile.
// When the receiver stalls, the result register holds and the sequencer waits.
// Reset clears the valid bits, the querier and sets age_limit to 260.
// The user must write age_limit through cfg_we/cfg_data only while idle; the block does not enforce it.
module igmp_snooping_table import igmp_pkg::*; #(
	parameter int NUM_ENTRIES = NumEntriesDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// frame_len, igmp_type, rx_port, group_addr, src_ip, dst_ip, src_mac, zero pad
	input  logic [167:0] s_axis_tdata,
	// req_type
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// accepted, send, forward_mask, table_action, entry_index, entry_mac, zero pad
	output logic [63:0]  m_axis_tdata,
	// result_kind
	output logic         m_axis_tuser,
	output logic         m_axis_tlast
);
	logic [62:0] item;

	igmp_ctrl #(.NUM_ENTRIES(NUM_ENTRIES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_item({s_axis_tdata[165:0], s_axis_tuser}),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_item(item)
	);

	assign m_axis_tuser = item[0];
	assign m_axis_tdata = {3'd0, item[61:1]};
	assign m_axis_tlast = item[62];
endmodule
